[rtl/circle_rasterizer_unit_assert.svh]
// Assertion macros used by the circle rasterizer point generator.
`ifndef CIRCLE_RASTERIZER_UNIT_ASSERT_SVH
`define CIRCLE_RASTERIZER_UNIT_ASSERT_SVH

// Clocked on clk_i, off while rst_ni is low.
`define CRZ_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("%m: assertion failed");

// Same, with a caller-supplied message.
`define CRZ_ASSERT_MSG(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

`endif

[rtl/crz_pkg.sv]
// Package: constants, types and helpers for the circle rasterizer.
`default_nettype none

package crz_pkg;

  localparam int CoordBitsDef = 12;
  localparam int RadiusBits   = 11;
  localparam int ScreenBits   = 14;
  localparam int OriginBits   = 12;
  localparam int WinBits      = 13;
  localparam int XBits        = 12;
  localparam int YBits        = 13;
  localparam int ErrBits      = 16;
  localparam int ErrExtBits   = 18;
  localparam int PaddrBits    = 4;
  localparam int DataBits     = 32;
  localparam int OctBits      = 3;

  localparam logic [OriginBits-1:0] OriginXRst = 12'd500;
  localparam logic [OriginBits-1:0] OriginYRst = 12'd250;
  localparam logic [WinBits-1:0]    WinWRst    = 13'd1000;
  localparam logic [WinBits-1:0]    WinHRst    = 13'd500;

  localparam logic [OctBits-1:0] OctLast = 3'd7;

  localparam logic ActStart = 1'b0;
  localparam logic ActStep  = 1'b1;

  typedef enum logic [1:0] {
    RegOriginX = 2'd0,
    RegOriginY = 2'd1,
    RegWinW    = 2'd2,
    RegWinH    = 2'd3
  } crz_reg_e;

  // One Bresenham position handed to the point generator.
  typedef struct packed {
    logic [RadiusBits-1:0] x;
    logic [RadiusBits-1:0] y;
    logic                  done;
  } crz_step_t;

  // Width of screen sums before truncation: center + offset + origin.
  function automatic int crz_sum_width(input int coord_bits);
    return ((coord_bits > 13) ? coord_bits : 13) + 3;
  endfunction

endpackage

`default_nettype wire

[rtl/crz_point_gen.sv]
// Point generator: expands one circle position into its eight screen points.
`default_nettype none
`include "circle_rasterizer_unit_assert.svh"

module crz_point_gen #(
  parameter int COORD_BITS = crz_pkg::CoordBitsDef,
  parameter int SUM_W      = crz_pkg::crz_sum_width(COORD_BITS)
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  load_i,
  input  crz_pkg::crz_step_t                    step_i,
  input  logic signed [SUM_W-1:0]               base_x_i,
  input  logic signed [SUM_W-1:0]               base_y_i,
  input  logic [crz_pkg::WinBits-1:0]           win_w_i,
  input  logic [crz_pkg::WinBits-1:0]           win_h_i,
  output logic                                  ready_o,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic signed [crz_pkg::ScreenBits-1:0] screen_x_o,
  output logic signed [crz_pkg::ScreenBits-1:0] screen_y_o,
  output logic                                  in_window_o,
  output logic [crz_pkg::OctBits-1:0]           octant_o,
  output logic                                  last_o,
  output logic                                  circle_done_o
);
  import crz_pkg::*;

  logic                   gen_q, gen_d;
  logic [OctBits-1:0]     cnt_q, cnt_d;
  crz_step_t              step_q;
  logic signed [SUM_W-1:0] bx_q, by_q;

  logic                   out_valid_q, out_valid_d;
  logic signed [ScreenBits-1:0] screen_x_q, screen_y_q;
  logic                   in_window_q, last_q, circle_done_q;
  logic [OctBits-1:0]     octant_q;

  logic                   adv, fin;
  logic [RadiusBits-1:0]  ax, ay;
  logic signed [SUM_W-1:0] axe, aye, sx, sy, ww_e, wh_e;
  logic                   inw;

  assign adv = gen_q && (!out_valid_q || !out_stall_i);
  assign fin = adv && (cnt_q == OctLast);
  assign ready_o = !gen_q || fin;

  // bit 0 swaps x/y, bit 1 mirrors the column, bit 2 mirrors the row
  always_comb begin
    ax   = cnt_q[0] ? step_q.y : step_q.x;
    ay   = cnt_q[0] ? step_q.x : step_q.y;
    axe  = $signed(SUM_W'(ax));
    aye  = $signed(SUM_W'(ay));
    sx   = cnt_q[1] ? (bx_q - axe) : (bx_q + axe);
    sy   = cnt_q[2] ? (by_q + aye) : (by_q - aye);
    ww_e = $signed(SUM_W'(win_w_i));
    wh_e = $signed(SUM_W'(win_h_i));
    inw  = !sx[SUM_W-1] && !sy[SUM_W-1] && (sx < ww_e) && (sy < wh_e);
  end

  always_comb begin
    gen_d = gen_q;
    cnt_d = cnt_q;
    if (load_i) begin
      gen_d = 1'b1;
      cnt_d = '0;
    end else if (adv) begin
      cnt_d = cnt_q + 1'b1;
      if (fin) gen_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (adv) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gen_q       <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      gen_q       <= gen_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      step_q <= step_i;
      bx_q   <= base_x_i;
      by_q   <= base_y_i;
    end
    if (adv) begin
      screen_x_q    <= sx[ScreenBits-1:0];
      screen_y_q    <= sy[ScreenBits-1:0];
      in_window_q   <= inw;
      octant_q      <= cnt_q;
      last_q        <= (cnt_q == OctLast);
      circle_done_q <= (cnt_q == OctLast) && step_q.done;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign screen_x_o    = screen_x_q;
  assign screen_y_o    = screen_y_q;
  assign in_window_o   = in_window_q;
  assign octant_o      = octant_q;
  assign last_o        = last_q;
  assign circle_done_o = circle_done_q;

  `CRZ_ASSERT_MSG(a_load_when_free, load_i |-> (!gen_q || fin), "load while points pending")
  `CRZ_ASSERT(a_done_on_last, (out_valid_q && circle_done_q) |-> last_q)
  `CRZ_ASSERT(a_last_is_oct7, out_valid_q |-> (last_q == (octant_q == OctLast)))
  `CRZ_ASSERT(a_out_from_gen, $rose(out_valid_q) |-> $past(gen_q))

endmodule

`default_nettype wire

[rtl/circle_rasterizer_unit.sv]
// An accepted step is loaded into the point generator's step register; its points then
// leave the single-point output register one point per cycle, eight in all, while the
// output is not stalled; the next step is taken as the last of them is registered;
// start transactions and steps that emit nothing are taken one per cycle when not busy.
// Reset (rst_ni low, async): no circle active, output empty, config at reset values.
`default_nettype none

module circle_rasterizer_unit #(
  parameter int COORD_BITS = crz_pkg::CoordBitsDef
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic                                  action_i,
  input  logic signed [COORD_BITS-1:0]          center_x_i,
  input  logic signed [COORD_BITS-1:0]          center_y_i,
  input  logic [crz_pkg::RadiusBits-1:0]        radius_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic signed [crz_pkg::ScreenBits-1:0] screen_x_o,
  output logic signed [crz_pkg::ScreenBits-1:0] screen_y_o,
  output logic                                  in_window_o,
  output logic [crz_pkg::OctBits-1:0]           octant_o,
  output logic                                  last_o,
  output logic                                  circle_done_o,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [crz_pkg::PaddrBits-1:0]         paddr,
  input  logic [crz_pkg::DataBits-1:0]          pwdata,
  output logic [crz_pkg::DataBits-1:0]          prdata,
  output logic                                  pready
);
  import crz_pkg::*;

  localparam int SumW = crz_sum_width(COORD_BITS);

  // configuration
  logic [OriginBits-1:0] origin_x_q, origin_y_q;
  logic [WinBits-1:0]    win_w_q, win_h_q;
  logic                  cfg_we;
  crz_reg_e              reg_sel;

  // walk state
  logic                         active_q, active_d;
  logic signed [COORD_BITS-1:0] cx_q, cx_d, cy_q, cy_d;
  logic [XBits-1:0]             x_q, x_d;
  logic signed [YBits-1:0]      y_q, y_d;
  logic signed [ErrBits-1:0]    err_q, err_d;

  logic                         in_acc, gen_ready, step_go, is_step;
  logic signed [ErrExtBits-1:0] xe, ye, de, dy_sum, dx_diff, nd_h, nd_v, nd_d;
  logic                         move_h, move_v, y_ge_x, done;
  logic [XBits-1:0]             nx;
  logic signed [YBits-1:0]      ny;
  logic signed [ErrBits-1:0]    nd;
  logic signed [SumW-1:0]       base_x, base_y;
  crz_step_t                    step;

  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite;
  assign reg_sel = crz_reg_e'(paddr[PaddrBits-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_x_q <= OriginXRst;
      origin_y_q <= OriginYRst;
      win_w_q    <= WinWRst;
      win_h_q    <= WinHRst;
    end else if (cfg_we) begin
      case (reg_sel)
        RegOriginX: origin_x_q <= pwdata[OriginBits-1:0];
        RegOriginY: origin_y_q <= pwdata[OriginBits-1:0];
        RegWinW:    win_w_q    <= pwdata[WinBits-1:0];
        RegWinH:    win_h_q    <= pwdata[WinBits-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      RegOriginX: prdata = DataBits'(origin_x_q);
      RegOriginY: prdata = DataBits'(origin_y_q);
      RegWinW:    prdata = DataBits'(win_w_q);
      RegWinH:    prdata = DataBits'(win_h_q);
      default:    prdata = '0;
    endcase
  end

  assign in_stall_o = !gen_ready;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign is_step    = (action_i == ActStep);
  assign y_ge_x     = (y_q >= $signed({1'b0, x_q}));
  assign step_go    = in_acc && is_step && active_q && y_ge_x;

  // three-way midpoint update; 2d+2y-1<=0 reduces to d+y<=0, 2d-2x-1<=0 to d-x<=0
  always_comb begin
    xe      = $signed({{(ErrExtBits-XBits){1'b0}}, x_q});
    ye      = $signed({{(ErrExtBits-YBits){y_q[YBits-1]}}, y_q});
    de      = $signed({{(ErrExtBits-ErrBits){err_q[ErrBits-1]}}, err_q});
    dy_sum  = de + ye;
    dx_diff = de - xe;
    nd_h    = ErrExtBits'(de + (xe <<< 1) + 3);
    nd_v    = ErrExtBits'(de - (ye <<< 1) + 3);
    nd_d    = ErrExtBits'(de + (xe <<< 1) - (ye <<< 1) + 6);
    move_h  = err_q[ErrBits-1] && (dy_sum <= 0);
    move_v  = !err_q[ErrBits-1] && (err_q != 0) && (dx_diff > 0);
    nx      = move_v ? x_q : x_q + 1'b1;
    ny      = move_h ? y_q : y_q - YBits'(1);
    if (move_h) begin
      nd = nd_h[ErrBits-1:0];
    end else if (move_v) begin
      nd = nd_v[ErrBits-1:0];
    end else begin
      nd = nd_d[ErrBits-1:0];
    end
    done = (ny < $signed({1'b0, nx}));
  end

  always_comb begin
    active_d = active_q;
    cx_d     = cx_q;
    cy_d     = cy_q;
    x_d      = x_q;
    y_d      = y_q;
    err_d    = err_q;
    if (in_acc && !is_step) begin
      active_d = 1'b1;
      cx_d     = center_x_i;
      cy_d     = center_y_i;
      x_d      = '0;
      y_d      = $signed({2'b00, radius_i});
      err_d    = $signed(ErrBits'(2) - {4'b0000, radius_i, 1'b0});
    end else if (step_go) begin
      x_d   = nx;
      y_d   = ny;
      err_d = nd;
      if (done) active_d = 1'b0;
    end else if (in_acc) begin
      active_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      cx_q     <= '0;
      cy_q     <= '0;
      x_q      <= '0;
      y_q      <= '0;
      err_q    <= '0;
    end else begin
      active_q <= active_d;
      cx_q     <= cx_d;
      cy_q     <= cy_d;
      x_q      <= x_d;
      y_q      <= y_d;
      err_q    <= err_d;
    end
  end

  // screen bases: column = cx + origin_x, row = origin_y - cy
  always_comb begin
    base_x = $signed({{(SumW-COORD_BITS){cx_q[COORD_BITS-1]}}, cx_q})
           + $signed(SumW'(origin_x_q));
    base_y = $signed(SumW'(origin_y_q))
           - $signed({{(SumW-COORD_BITS){cy_q[COORD_BITS-1]}}, cy_q});
    step.x    = x_q[RadiusBits-1:0];
    step.y    = y_q[RadiusBits-1:0];
    step.done = done;
  end

  crz_point_gen #(
    .COORD_BITS (COORD_BITS),
    .SUM_W      (SumW)
  ) u_point_gen (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (step_go),
    .step_i        (step),
    .base_x_i      (base_x),
    .base_y_i      (base_y),
    .win_w_i       (win_w_q),
    .win_h_i       (win_h_q),
    .ready_o       (gen_ready),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .screen_x_o    (screen_x_o),
    .screen_y_o    (screen_y_o),
    .in_window_o   (in_window_o),
    .octant_o      (octant_o),
    .last_o        (last_o),
    .circle_done_o (circle_done_o)
  );

endmodule

`default_nettype wire

[tb/tb_circle_rasterizer_unit.sv]
// Self-checking testbench for circle_rasterizer_unit: directed table, then random circles.
`default_nettype none

module tb_circle_rasterizer_unit;
  import crz_pkg::*;

  typedef struct packed {
    logic signed [ScreenBits-1:0] sx;
    logic signed [ScreenBits-1:0] sy;
    logic                         inw;
    logic [OctBits-1:0]           oct;
    logic                         last;
    logic                         done;
  } screen_point_t;

  // How a directed row is checked: by the predictor, no points, or eight center copies.
  typedef enum logic [1:0] {ChkModel, ChkNone, ChkCenter8} chk_e;

  typedef struct packed {
    logic                           act;
    logic signed [CoordBitsDef-1:0] cx;
    logic signed [CoordBitsDef-1:0] cy;
    logic [RadiusBits-1:0]          r;
    chk_e                           chk;
    logic signed [ScreenBits-1:0]   sx;
    logic signed [ScreenBits-1:0]   sy;
    logic                           inw;
  } dir_row_t;

  localparam int DirN = 26;
  localparam dir_row_t DirTab [DirN] = '{
    '{ActStep,      0,     0,    0, ChkNone,        0,     0, 0},  // no circle yet
    '{ActStart,     0,     0,    0, ChkNone,        0,     0, 0},
    '{ActStep,      0,     0,    0, ChkCenter8,   500,   250, 1},  // radius zero
    '{ActStep,      0,     0,    0, ChkNone,        0,     0, 0},  // circle already over
    '{ActStart,  2047, -2048,    0, ChkNone,        0,     0, 0},
    '{ActStep,      0,     0,    0, ChkCenter8,  2547,  2298, 0},
    '{ActStart, -2048,  2047,    0, ChkNone,        0,     0, 0},
    '{ActStep,      0,     0,    0, ChkCenter8, -1548, -1797, 0},
    '{ActStart,   499,     0,    0, ChkNone,        0,     0, 0},
    '{ActStep,      0,     0,    0, ChkCenter8,   999,   250, 1},  // right edge, inside
    '{ActStart,  -500,  -249,    0, ChkNone,        0,     0, 0},
    '{ActStep,      0,     0,    0, ChkCenter8,     0,   499, 1},  // left/bottom edge
    '{ActStart,   500,   250,    0, ChkNone,        0,     0, 0},
    '{ActStep,      0,     0,    0, ChkCenter8,  1000,     0, 0},  // one past right edge
    '{ActStart,     0,     0,    1, ChkModel,       0,     0, 0},
    '{ActStep,      0,     0,    0, ChkModel,       0,     0, 0},
    '{ActStep,      0,     0,    0, ChkModel,       0,     0, 0},
    '{ActStart,    10,    -5,    5, ChkModel,       0,     0, 0},
    '{ActStep,      0,     0,    0, ChkModel,       0,     0, 0},
    '{ActStep,      0,     0,    0, ChkModel,       0,     0, 0},
    '{ActStep,      0,     0,    0, ChkModel,       0,     0, 0},
    '{ActStart, -2048, -2048, 2047, ChkModel,       0,     0, 0},  // abandons r=5 circle
    '{ActStep,      0,     0,    0, ChkModel,       0,     0, 0},
    '{ActStep,      0,     0,    0, ChkModel,       0,     0, 0},
    '{ActStart,  2047,  2047, 1365, ChkModel,       0,     0, 0},
    '{ActStep,      0,     0,    0, ChkModel,       0,     0, 0}
  };

  logic                           clk_i;
  logic                           rst_ni = 1'b0;
  logic                           in_valid_i = 1'b0;
  logic                           in_stall_o;
  logic                           action_i = 1'b0;
  logic signed [CoordBitsDef-1:0] center_x_i = '0;
  logic signed [CoordBitsDef-1:0] center_y_i = '0;
  logic [RadiusBits-1:0]          radius_i = '0;
  logic                           out_valid_o;
  logic                           out_stall_i = 1'b0;
  logic signed [ScreenBits-1:0]   screen_x_o;
  logic signed [ScreenBits-1:0]   screen_y_o;
  logic                           in_window_o;
  logic [OctBits-1:0]             octant_o;
  logic                           last_o;
  logic                           circle_done_o;
  logic                           psel = 1'b0;
  logic                           penable = 1'b0;
  logic                           pwrite = 1'b0;
  logic [PaddrBits-1:0]           paddr = '0;
  logic [DataBits-1:0]            pwdata = '0;
  logic [DataBits-1:0]            prdata;
  logic                           pready;

  circle_rasterizer_unit u_top (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .action_i, .center_x_i, .center_y_i,
    .radius_i, .out_valid_o, .out_stall_i, .screen_x_o, .screen_y_o, .in_window_o,
    .octant_o, .last_o, .circle_done_o, .psel, .penable, .pwrite, .paddr, .pwdata,
    .prdata, .pready
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Predictor state: window setup and the Bresenham walk.
  logic [OriginBits-1:0] org_x = OriginXRst;
  logic [OriginBits-1:0] org_y = OriginYRst;
  logic [WinBits-1:0]    win_w = WinWRst;
  logic [WinBits-1:0]    win_h = WinHRst;
  bit walk_active = 1'b0;
  int walk_cx = 0, walk_cy = 0, walk_x = 0, walk_y = 0, walk_err = 0;

  screen_point_t pending_points [$];
  int mismatches = 0;
  int points_seen = 0;
  int circles_closed = 0;
  int items_sent = 0;
  int settings_used = 1;
  int gap_pct = 0;
  int stall_pct = 0;

  initial begin
    #3000000;
    $display("%0t: timeout, %0d points still outstanding", $time, pending_points.size());
    $display("end of test: mismatches");
    $finish;
  end

  function automatic screen_point_t map_point(int px, int py, int k, bit fin, bit done);
    int sx, sy;
    screen_point_t p;
    sx = px + int'(org_x);
    sy = int'(org_y) - py;
    p.sx = sx[ScreenBits-1:0];
    p.sy = sy[ScreenBits-1:0];
    p.inw = sx >= 0 && sy >= 0 && sx < int'(win_w) && sy < int'(win_h);
    p.oct = k[OctBits-1:0];
    p.last = fin;
    p.done = fin && done;
    return p;
  endfunction

  // Advance the walk by one input transaction; queue its points when keep is set.
  function automatic int trace_circle_step(logic act, logic signed [CoordBitsDef-1:0] cx,
                                           logic signed [CoordBitsDef-1:0] cy,
                                           logic [RadiusBits-1:0] r, bit keep);
    int x, y, d, nx, ny, nd, px, py;
    bit diag, done;
    if (act == ActStart) begin
      walk_cx = cx;
      walk_cy = cy;
      walk_x = 0;
      walk_y = int'(r);
      walk_err = 2 * (1 - int'(r));
      walk_active = 1'b1;
      return 0;
    end
    if (!walk_active || walk_y < walk_x) begin
      walk_active = 1'b0;
      return 0;
    end
    x = walk_x;
    y = walk_y;
    d = walk_err;
    nx = x;
    ny = y;
    nd = d;
    diag = 1'b0;
    if (d < 0) begin
      if (2 * d + 2 * y - 1 <= 0) begin
        nx = x + 1;
        nd = d + 2 * nx + 1;
      end else begin
        diag = 1'b1;
      end
    end else if (d > 0) begin
      if (2 * d - 2 * x - 1 <= 0) begin
        diag = 1'b1;
      end else begin
        ny = y - 1;
        nd = d - 2 * ny + 1;
      end
    end else begin
      diag = 1'b1;
    end
    if (diag) begin
      nx = x + 1;
      ny = y - 1;
      nd = d + 2 * nx - 2 * ny + 2;
    end
    walk_x = nx;
    walk_y = ny;
    walk_err = nd;
    done = ny < nx;
    if (done) walk_active = 1'b0;
    for (int k = 0; k < 8; k++) begin
      case (k)
        0: begin px = x;  py = y;  end
        1: begin px = y;  py = x;  end
        2: begin px = -x; py = y;  end
        3: begin px = -y; py = x;  end
        4: begin px = x;  py = -y; end
        5: begin px = y;  py = -x; end
        6: begin px = -x; py = -y; end
        default: begin px = -y; py = -x; end
      endcase
      if (keep) pending_points.push_back(map_point(walk_cx + px, walk_cy + py, k, k == 7, done));
    end
    return 8;
  endfunction

  function automatic void check_field(string fname, int want, int got);
    if (want != got) begin
      $display("%0t: %s expected %0d, got %0d", $time, fname, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i) begin
    screen_point_t want;
    if (out_valid_o && !out_stall_i) begin
      points_seen++;
      if (circle_done_o) circles_closed++;
      if (pending_points.size() == 0) begin
        $display("%0t: unexpected point (%0d,%0d) octant %0d", $time, screen_x_o, screen_y_o,
                 octant_o);
        mismatches++;
      end else begin
        want = pending_points.pop_front();
        check_field("screen_x", want.sx, screen_x_o);
        check_field("screen_y", want.sy, screen_y_o);
        check_field("in_window", want.inw, in_window_o);
        check_field("octant", want.oct, octant_o);
        check_field("last", want.last, last_o);
        check_field("circle_done", want.done, circle_done_o);
      end
    end
  end

  always @(posedge clk_i) out_stall_i <= ($urandom_range(0, 99) < stall_pct);

  task automatic send_item(input logic act, input logic signed [CoordBitsDef-1:0] cx,
                           input logic signed [CoordBitsDef-1:0] cy,
                           input logic [RadiusBits-1:0] r, input bit keep, output int n_pts);
    while ($urandom_range(0, 99) < gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    action_i <= act;
    center_x_i <= cx;
    center_y_i <= cy;
    radius_i <= r;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    n_pts = trace_circle_step(act, cx, cy, r, keep);
    items_sent++;
  endtask

  // Rewrite all four window registers; only called with nothing in flight.
  task automatic load_window(int ox, int oy, int ww, int wh);
    int vals [4];
    crz_reg_e idx;
    vals = '{ox, oy, ww, wh};
    for (int i = 0; i < 4; i++) begin
      idx = crz_reg_e'(i);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= vals[i];
      @(posedge clk_i);
      penable <= 1'b1;
      @(posedge clk_i);
      while (!pready) @(posedge clk_i);
      case (idx)
        RegOriginX: org_x = vals[i][OriginBits-1:0];
        RegOriginY: org_y = vals[i][OriginBits-1:0];
        RegWinW:    win_w = vals[i][WinBits-1:0];
        default:    win_h = vals[i][WinBits-1:0];
      endcase
    end
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    settings_used++;
  endtask

  initial begin
    dir_row_t row;
    int n, steps, made, sel, budget;
    logic signed [CoordBitsDef-1:0] cx, cy;
    logic [RadiusBits-1:0] r;

    made = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DirTab[i]) begin
      row = DirTab[i];
      send_item(row.act, row.cx, row.cy, row.r, row.chk == ChkModel, n);
      if (row.chk == ChkCenter8) begin
        for (int k = 0; k < 8; k++) begin
          pending_points.push_back('{row.sx, row.sy, row.inw, OctBits'(k), k == 7, k == 7});
        end
      end
    end

    for (int ph = 0; ph < 4; ph++) begin
      in_valid_i <= 1'b0;
      while (pending_points.size() != 0) @(posedge clk_i);
      repeat (12) @(posedge clk_i);
      case (ph)
        0: begin load_window(0, 4095, 4096, 4096); gap_pct = 0;  stall_pct = 0;  end
        1: begin load_window(4095, 0, 0, 8191);    gap_pct = 83; stall_pct = 0;  end
        2: begin
          load_window($urandom_range(0, 4095), $urandom_range(0, 4095),
                      $urandom_range(1, 4096), $urandom_range(1, 4096));
          gap_pct = 0;
          stall_pct = 83;
        end
        default: begin load_window(2048, 2048, 8191, 0); gap_pct = 36; stall_pct = 36; end
      endcase
      budget = items_sent + 21;
      while (items_sent < budget) begin
        // a stray step now and then, on a live or finished circle
        if ($urandom_range(0, 9) == 0) begin
          send_item(ActStep, CoordBitsDef'($urandom), CoordBitsDef'($urandom),
                    RadiusBits'($urandom), 1'b1, n);
          if (n > 0) made++;
        end
        sel = $urandom_range(0, 9);
        if (sel < 7) r = RadiusBits'($urandom_range(0, 20));
        else if (sel < 9) r = RadiusBits'($urandom_range(21, 300));
        else r = RadiusBits'($urandom_range(0, 2047));
        if ($urandom_range(0, 1) == 0) begin
          cx = CoordBitsDef'($urandom);
          cy = CoordBitsDef'($urandom);
        end else begin
          cx = CoordBitsDef'(int'($urandom_range(0, 80)) - 40);
          cy = CoordBitsDef'(int'($urandom_range(0, 80)) - 40);
        end
        send_item(ActStart, cx, cy, r, 1'b1, n);
        steps = $urandom_range(1, 18);
        for (int s = 0; s < steps && items_sent < budget; s++) begin
          send_item(ActStep, CoordBitsDef'($urandom), CoordBitsDef'($urandom),
                    RadiusBits'($urandom), 1'b1, n);
          if (n > 0) made++;
        end
      end
    end
    in_valid_i <= 1'b0;

    while (pending_points.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);

    $display("run covered %0d input transactions under %0d window settings,", items_sent,
             settings_used);
    $display("%0d random steps on live circles, %0d points compared and %0d circles closed",
             made, points_seen, circles_closed);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

`default_nettype wire

[files.f]
+incdir+rtl
rtl/crz_pkg.sv
rtl/crz_point_gen.sv
rtl/circle_rasterizer_unit.sv
tb/tb_circle_rasterizer_unit.sv
